// ===== hdl/pmmt_pkg.sv =====
// Shared types, codes and power-on map layout for the paged memory map translator.
package pmmt_pkg;

   localparam int MAP_ENTRIES = 256;
   localparam int IDX_W       = 8;
   localparam int VIS_W       = 24;

   // Operation codes
   localparam logic [1:0] OP_SET_BANK  = 2'd0;
   localparam logic [1:0] OP_TRANSLATE = 2'd1;
   localparam logic [1:0] OP_FIND      = 2'd2;
   localparam logic [1:0] OP_NOP       = 2'd3;

   // Region types
   localparam logic [1:0] REGION_NONE  = 2'd0;
   localparam logic [1:0] REGION_RAM   = 2'd1;
   localparam logic [1:0] REGION_ROM   = 2'd2;
   localparam logic [1:0] REGION_EXT   = 2'd3;

   // Power-on bank-page bases of the four 64-entry quarters
   localparam logic [8:0] INIT_BASE_Q0 = 9'd0;
   localparam logic [8:0] INIT_BASE_Q1 = 9'd320;
   localparam logic [8:0] INIT_BASE_Q2 = 9'd128;
   localparam logic [8:0] INIT_BASE_Q3 = 9'd0;

   localparam logic [4:0] BUS_WIDTH_RESET = 5'd16;
   localparam logic [4:0] BUS_WIDTH_MIN   = 5'd8;
   localparam logic [4:0] BUS_WIDTH_MAX   = 5'd24;
   localparam logic [4:0] PAGE_SHIFT_MIN  = 5'd8;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [23:0] cpu_address;
      logic [7:0]  start_page;
      logic [1:0]  region_type;
      logic [7:0]  bank_number;
      logic [4:0]  size_log2;
      logic [31:0] physical_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  found_type;
      logic [15:0] page_number;
      logic [31:0] absolute_address;
      logic [23:0] visible_address;
      logic        found;
   } rsp_type;

   // Address geometry derived from the bus width
   typedef struct packed {
      logic [4:0]  shift;
      logic [15:0] pmask;
      logic [23:0] busmask;
   } geom_type;

   // Map write strobe; the page travels on its own port (width is a parameter)
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [1:0]       region;
   } map_wr_type;

   // Power-on region of an entry: rom in the first quarter, ram elsewhere
   function automatic logic [1:0] init_region(input logic [IDX_W-1:0] idx);
      init_region = (idx[7:6] == 2'b00) ? REGION_ROM : REGION_RAM;
   endfunction

   // Power-on bank-page number of an entry
   function automatic logic [8:0] init_page(input logic [IDX_W-1:0] idx);
      logic [8:0] base;
      unique case (idx[7:6])
         2'b00: base = INIT_BASE_Q0;
         2'b01: base = INIT_BASE_Q1;
         2'b10: base = INIT_BASE_Q2;
         2'b11: base = INIT_BASE_Q3;
         default: base = INIT_BASE_Q0;
      endcase
      init_page = base + {3'b000, idx[5:0]};
   endfunction

endpackage

// ===== hdl/pmmt_map_ram.sv =====
// Page map memory: one write port, one registered read port, power-on layout via valid bits.
module pmmt_map_ram #(
   parameter int PAGE_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pmmt_pkg::map_wr_type wr,
   input  logic [PAGE_W-1:0]    wr_page,
   input  logic                 rd_en,
   input  logic [7:0]           rd_idx,
   output logic [1:0]           rd_region,
   output logic [PAGE_W-1:0]    rd_page
);
   import pmmt_pkg::*;

   logic [PAGE_W+1:0]      map_mem_ff [MAP_ENTRIES];
   logic [MAP_ENTRIES-1:0] valid_ff;
   logic [PAGE_W+1:0]      rd_data_ff;
   logic                   rd_valid_ff;
   logic [IDX_W-1:0]       rd_idx_ff;

   // Storage array
   always_ff @(posedge clock) begin
      if (wr.en) begin
         map_mem_ff[wr.idx] <= {wr.region, wr_page};
      end
      if (rd_en) begin
         rd_data_ff  <= map_mem_ff[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
         rd_idx_ff   <= rd_idx;
      end
   end

   // Written-since-reset flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   // Unwritten entries show the power-on layout
   always_comb begin
      if (rd_valid_ff) begin
         rd_region = rd_data_ff[PAGE_W+1:PAGE_W];
         rd_page   = rd_data_ff[PAGE_W-1:0];
      end else begin
         rd_region = init_region(rd_idx_ff);
         rd_page   = PAGE_W'(init_page(rd_idx_ff));
      end
   end

endmodule

// ===== hdl/pmmt_seq.sv =====
// Operation sequencer: walks the map for set_bank and find, reads it once for translate.
module pmmt_seq #(
   parameter int PAGE_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pmmt_pkg::req_type    req_data,
   input  pmmt_pkg::geom_type   geom,
   output logic                 res_valid,
   output pmmt_pkg::rsp_type    res_data,
   input  logic                 res_take,
   output pmmt_pkg::map_wr_type map_wr,
   output logic [PAGE_W-1:0]    map_wr_page,
   output logic                 map_rd_en,
   output logic [7:0]           map_rd_idx,
   input  logic [1:0]           map_rd_region,
   input  logic [PAGE_W-1:0]    map_rd_page
);
   import pmmt_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SETUP   = 3'd1;
   localparam logic [2:0] ST_FILL    = 3'd2;
   localparam logic [2:0] ST_TR_RD   = 3'd3;
   localparam logic [2:0] ST_TR_DATA = 3'd4;
   localparam logic [2:0] ST_FIND    = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   logic [2:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [8:0]        cnt_ff, cnt_in;
   logic [7:0]        last_ff, last_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [7:0]        cmp_idx_ff, cmp_idx_in;
   rsp_type           res_ff, res_in;

   logic [4:0]  fill_n;
   logic [31:0] fill_base;
   logic [31:0] fill_skip;
   logic [23:0] tr_addr;
   logic [23:0] want_page;
   logic        match;
   rsp_type     res_plain;

   // Run geometry and address terms
   always_comb begin
      fill_n    = (req_ff.size_log2 > 5'd8) ? (req_ff.size_log2 - 5'd8) : 5'd0;
      fill_base = 32'(req_ff.bank_number) << fill_n;
      // runs longer than the map only keep their last 256 writes
      fill_skip = (fill_n >= 5'd8) ? ((32'd1 << fill_n) - 32'd256) : 32'd0;
      tr_addr   = req_ff.cpu_address & geom.busmask;
      want_page = 24'(req_ff.physical_address >> geom.shift);
      match     = cmp_vld_ff && (map_rd_region == req_ff.region_type)
                  && (24'(map_rd_page) == want_page);
      res_plain = '0;
      res_plain.found = 1'b1;
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      page_in     = page_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      res_in      = res_ff;
      map_wr      = '0;
      map_wr_page = page_ff;
      map_rd_en   = 1'b0;
      map_rd_idx  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               cnt_in = '0;
               unique case (req_data.opcode)
                  OP_SET_BANK:  state_in = ST_SETUP;
                  OP_TRANSLATE: state_in = ST_TR_RD;
                  OP_FIND:      state_in = ST_FIND;
                  OP_NOP: begin
                     res_in   = res_plain;
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP: begin
            page_in  = PAGE_W'(fill_base + fill_skip);
            last_in  = (fill_n >= 5'd8) ? 8'hff : 8'((9'd1 << fill_n) - 9'd1);
            cnt_in   = '0;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            // one entry per cycle, index wraps at the map size
            map_wr.en     = 1'b1;
            map_wr.idx    = req_ff.start_page + cnt_ff[7:0];
            map_wr.region = req_ff.region_type;
            page_in       = page_ff + PAGE_W'(1);
            cnt_in        = cnt_ff + 9'd1;
            if (cnt_ff[7:0] == last_ff) begin
               res_in   = res_plain;
               state_in = ST_DONE;
            end
         end
         ST_TR_RD: begin
            map_rd_en  = 1'b1;
            map_rd_idx = 8'(tr_addr >> geom.shift);
            state_in   = ST_TR_DATA;
         end
         ST_TR_DATA: begin
            res_in                  = res_plain;
            res_in.found_type       = map_rd_region;
            res_in.page_number      = 16'(map_rd_page);
            res_in.absolute_address = (32'(map_rd_page) << geom.shift)
                                      | 32'(tr_addr[15:0] & geom.pmask);
            res_in.visible_address  = tr_addr;
            state_in                = ST_DONE;
         end
         ST_FIND: begin
            // read stage issues entry cnt, compare stage checks the entry read last cycle
            map_rd_en  = !cnt_ff[8];
            map_rd_idx = cnt_ff[7:0];
            cmp_vld_in = !cnt_ff[8];
            cmp_idx_in = cnt_ff[7:0];
            if (!cnt_ff[8]) begin
               cnt_in = cnt_ff + 9'd1;
            end
            if (match) begin
               res_in                 = '0;
               res_in.visible_address = (24'(cmp_idx_ff) << geom.shift)
                                        | 24'(req_ff.physical_address[15:0] & geom.pmask);
               res_in.found           = 1'b1;
               state_in               = ST_DONE;
            end else if (cmp_vld_ff && (cmp_idx_ff == 8'hff)) begin
               res_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      cnt_ff     <= cnt_in;
      last_ff    <= last_in;
      page_ff    <= page_in;
      cmp_idx_ff <= cmp_idx_in;
      res_ff     <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;

endmodule

// ===== hdl/paged_memory_map_translator_unit.sv =====
// Paged memory map translator top level: bus width register, geometry, response register.
//
// Keeps a 256-entry page map (region type and bank-page number per entry) in a memory with
// one write port and one registered read port, and serves one request word at a time. The map
// comes out of reset in its power-on layout at once: no clearing pass, per-entry written
// flags select the built-in layout. Set_bank and find walk the map one entry per cycle
// through the memory's ports; a finished response waits while the response register stays
// full. A new request is taken while the previous response word still waits in the output
// register.
module paged_memory_map_translator_unit #(
   parameter int PAGE_NUM_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pmmt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pmmt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_data
);
   import pmmt_pkg::*;

   logic [4:0] bus_width_ff, bus_width_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;

   logic [4:0]  eff_width;
   geom_type    geom;
   logic        res_valid;
   rsp_type     res_data;
   logic        res_take;

   map_wr_type          map_wr;
   logic [PAGE_NUM_WIDTH-1:0] map_wr_page;
   logic                map_rd_en;
   logic [7:0]          map_rd_idx;
   logic [1:0]          map_rd_region;
   logic [PAGE_NUM_WIDTH-1:0] map_rd_page;

   // Bus width register
   assign csr_ready    = 1'b1;
   assign bus_width_in = (csr_valid && csr_ready) ? csr_data : bus_width_ff;

   // Geometry from the clamped width
   always_comb begin
      if (bus_width_ff < BUS_WIDTH_MIN) begin
         eff_width = BUS_WIDTH_MIN;
      end else if (bus_width_ff > BUS_WIDTH_MAX) begin
         eff_width = BUS_WIDTH_MAX;
      end else begin
         eff_width = bus_width_ff;
      end
      geom.shift   = (eff_width > 5'd16) ? (eff_width - 5'd8) : PAGE_SHIFT_MIN;
      geom.pmask   = 16'((17'd1 << (eff_width - 5'd8)) - 17'd1);
      geom.busmask = 24'((25'd1 << eff_width) - 25'd1);
   end

   // Response register
   assign res_take     = res_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = res_take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_width_ff <= BUS_WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         bus_width_ff <= bus_width_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pmmt_seq #(
      .PAGE_W (PAGE_NUM_WIDTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .geom          (geom),
      .res_valid     (res_valid),
      .res_data      (res_data),
      .res_take      (res_take),
      .map_wr        (map_wr),
      .map_wr_page   (map_wr_page),
      .map_rd_en     (map_rd_en),
      .map_rd_idx    (map_rd_idx),
      .map_rd_region (map_rd_region),
      .map_rd_page   (map_rd_page)
   );

   pmmt_map_ram #(
      .PAGE_W (PAGE_NUM_WIDTH)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .wr        (map_wr),
      .wr_page   (map_wr_page),
      .rd_en     (map_rd_en),
      .rd_idx    (map_rd_idx),
      .rd_region (map_rd_region),
      .rd_page   (map_rd_page)
   );

endmodule
